FILE: rtl/dmgt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmgt_pkg
// shared widths, function codes and request/result types of the direct-mapped
// group table
// ----------------------------------------------------------------------------
package dmgt_pkg;

    localparam int FUNC_W      = 2;
    localparam int KEY_W       = 10;
    localparam int RECORD_W    = 64;
    localparam int COUNT_W     = 11;

    localparam int NUM_ROWS_DEF    = 1024;
    localparam int RECORD_BITS_DEF = 64;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_FIND    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET_END = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [KEY_W-1:0]    group_key;
        logic [RECORD_W-1:0] group_record;
        logic                insert_new;
        logic [COUNT_W-1:0]  new_end;
    } t_req;

    typedef struct packed {
        logic               found;
        logic [KEY_W-1:0]   row_index;
        logic               no_row;
        logic [COUNT_W-1:0] row_count;
        logic               end_accepted;
    } t_res;

endpackage

FILE: rtl/dmgt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmgt_ram
// generic single-clock ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module dmgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/direct_mapped_group_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_group_table_unit
// group-by table indexed directly by the group code, with occupied bitmap,
// record store, insertion-order list and row count
// ----------------------------------------------------------------------------
// result path: a taken request is registered in the request stage while its
//   occupied bit is read, then decided and written back into the result register
// throughput: one find or set-end request per cycle, back to back, while no
//   sweep is running; a clear holds busy until the occupied bitmap is swept
// reset: synchronous, active low; afterwards busy stays high while the
//   occupied bitmap is swept to zero
// results cannot be stalled: o_done is a one-cycle strobe
module direct_mapped_group_table_unit #(
    parameter int NUM_ROWS    = dmgt_pkg::NUM_ROWS_DEF,
    parameter int RECORD_BITS = dmgt_pkg::RECORD_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  dmgt_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output dmgt_pkg::t_res o_res
);

    import dmgt_pkg::*;

    localparam int AW    = $clog2(NUM_ROWS);
    localparam int CNT_W = $clog2(NUM_ROWS + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // request stage: request held while its occupied bit is read
    logic          r_s1_vld;
    t_req          r_s1;

    // result register
    logic          r_done;
    t_res          r_res;

    // row count
    logic [CNT_W-1:0] r_rows;
    logic [CNT_W-1:0] n_rows;

    // bitmap sweep after reset and on clear
    logic          r_sweeping;
    logic [AW-1:0] r_sweep_addr;

    // forwarding of the occupied bit written in the previous cycle
    logic          r_fwd_vld;
    logic [AW-1:0] r_fwd_addr;

    logic          accept;
    logic [AW-1:0] s1_addr;
    logic          s1_in_range;
    logic          occ_rdata;
    logic          occ_hit;
    logic          do_insert;
    logic          do_append;
    logic          start_sweep;
    logic          occ_we;
    logic [AW-1:0] occ_waddr;
    logic          occ_wdata;
    t_res          n_res;

    assign busy   = r_sweeping | (r_s1_vld & (r_s1.func == FUNC_CLEAR));
    assign accept = start & ~busy;

    assign s1_addr     = AW'(r_s1.group_key);
    assign s1_in_range = int'(r_s1.group_key) < NUM_ROWS;

    // a read issued at the edge of a write sees the old bit, so forward it
    assign occ_hit = occ_rdata | (r_fwd_vld & (r_fwd_addr == s1_addr));

    // decide on the request in the request stage
    always_comb begin
        n_res       = '0;
        n_rows      = r_rows;
        do_insert   = 1'b0;
        do_append   = 1'b0;
        start_sweep = 1'b0;
        if (r_s1_vld) begin
            case (r_s1.func)
                FUNC_FIND: begin
                    if (!s1_in_range) begin
                        n_res.no_row = 1'b1;
                    end else if (occ_hit) begin
                        n_res.found     = 1'b1;
                        n_res.row_index = r_s1.group_key;
                    end else if (!r_s1.insert_new) begin
                        n_res.no_row = 1'b1;
                    end else begin
                        n_res.row_index = r_s1.group_key;
                        do_insert       = 1'b1;
                        // a full count keeps the bit and record but does not append
                        if (r_rows < CNT_W'(NUM_ROWS)) begin
                            do_append = 1'b1;
                            n_rows    = r_rows + CNT_W'(1);
                        end
                    end
                end
                FUNC_CLEAR: begin
                    n_rows      = '0;
                    start_sweep = 1'b1;
                end
                FUNC_SET_END: begin
                    if (CMP_W'(r_s1.new_end) <= CMP_W'(r_rows)) begin
                        n_rows             = CNT_W'(r_s1.new_end);
                        n_res.end_accepted = 1'b1;
                    end
                end
                default: begin
                    // unused code: nothing changes
                end
            endcase
        end
        n_res.row_count = COUNT_W'(n_rows);
    end

    // occupied bitmap write port: sweep wins, requests are held off meanwhile
    always_comb begin
        if (r_sweeping) begin
            occ_we    = 1'b1;
            occ_waddr = r_sweep_addr;
            occ_wdata = 1'b0;
        end else begin
            occ_we    = do_insert;
            occ_waddr = s1_addr;
            occ_wdata = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld     <= 1'b0;
            r_done       <= 1'b0;
            r_rows       <= '0;
            r_sweeping   <= 1'b1;
            r_sweep_addr <= '0;
            r_fwd_vld    <= 1'b0;
        end else begin
            r_s1_vld  <= accept;
            r_done    <= r_s1_vld;
            r_rows    <= n_rows;
            r_fwd_vld <= do_insert;
            if (start_sweep) begin
                r_sweeping   <= 1'b1;
                r_sweep_addr <= '0;
            end else if (r_sweeping) begin
                if (r_sweep_addr == AW'(NUM_ROWS - 1)) begin
                    r_sweeping <= 1'b0;
                end
                r_sweep_addr <= r_sweep_addr + AW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= i_req;
        end
        r_res      <= n_res;
        r_fwd_addr <= s1_addr;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    // occupied bitmap
    dmgt_ram #(
        .WIDTH (1),
        .DEPTH (NUM_ROWS)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (occ_we),
        .i_waddr (occ_waddr),
        .i_wdata (occ_wdata),
        .i_re    (accept),
        .i_raddr (AW'(i_req.group_key)),
        .o_rdata (occ_rdata)
    );

    // record store, written on insert only
    dmgt_ram #(
        .WIDTH (RECORD_BITS),
        .DEPTH (NUM_ROWS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (do_insert),
        .i_waddr (s1_addr),
        .i_wdata (r_s1.group_record[RECORD_BITS-1:0]),
        .i_re    (1'b0),
        .i_raddr (s1_addr),
        .o_rdata ()
    );

    // insertion-order list, appended at the current count
    dmgt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (NUM_ROWS)
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (do_append),
        .i_waddr (r_rows[AW-1:0]),
        .i_wdata (r_s1.group_key),
        .i_re    (1'b0),
        .i_raddr (r_rows[AW-1:0]),
        .o_rdata ()
    );

    // every accepted request gives exactly one result strobe
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |=> o_done)
        else $error("request without result");

    // no request taken while the bitmap is being swept
    a_sweep_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweeping |-> !accept)
        else $error("request taken during sweep");

    // count never exceeds the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows <= CNT_W'(NUM_ROWS))
        else $error("row count beyond table size");

    // found and no row are exclusive
    a_found_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_res.found && o_res.no_row))
        else $error("found together with no row");

endmodule
